@@ hdl/adfc_pkg.sv @@
`timescale 1ns / 1ps
package adfc_pkg;
  typedef enum logic [2:0] {
    K_DATA = 3'd0, K_CTRL = 3'd1, K_DIV = 3'd2, K_LEVEL = 3'd3,
    K_STATUS = 3'd4, K_CMD = 3'd5, K_DIVRD = 3'd6, K_TICK = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_EXEC, S_DIV, S_TICK, S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] sample;
    logic       irq_line;
  } out_item_t;

  localparam logic [7:0]  MIDLINE      = 8'd128;
  localparam logic [7:0]  MIN_DIV      = 8'd45;
  localparam logic [7:0]  FALLBACK_DIV = 8'd125;
  localparam logic [19:0] CLOCK_HZ     = 20'd1000000;
  localparam logic [7:0]  ST_FULL      = 8'h08;
  localparam logic [7:0]  ST_EMPTY     = 8'h04;
  localparam logic [7:0]  ST_NEAR      = 8'h02;
  localparam logic [7:0]  ST_IRQ       = 8'h01;
  localparam logic [15:0] STEP_MAX     = 16'hFFFF;
endpackage

@@ hdl/adfc_if.sv @@
`timescale 1ns / 1ps
interface adfc_in_if;
  logic valid;
  logic ready;
  logic [2:0] kind;
  logic [7:0] data;
  modport source (output valid, kind, data, input ready);
  modport sink (input valid, kind, data, output ready);
endinterface

interface adfc_out_if;
  logic valid;
  logic ready;
  logic [7:0] read_data;
  logic [7:0] sample;
  logic irq_line;
  modport source (output valid, read_data, sample, irq_line, input ready);
  modport sink (input valid, read_data, sample, irq_line, output ready);
endinterface

@@ hdl/audio_dac_fifo_controller_top.sv @@
`timescale 1ns / 1ps
// channel  dir  payload                        handshake
// in       in   kind[2:0], data[7:0]           valid/ready
// out      out  read_data, sample, irq_line    valid/ready
// cfg      in   cfg_data[16:0] output rate     cfg_we
//
// Register and read items pass through the accept, execute and output states before
// the result is offered; ticks also pass through a TICK state, which takes the registered memory read.
// Divisor writes run one shared restoring divider, first for 1e6/div and then for the step.
// After reset and after a level write of 0 the FIFO is swept back to 128,
// one entry a cycle over all FIFO_DEPTH entries, with the input not ready; the level
// write's result is offered as the sweep starts.
// One item at a time; a held result stalls the next item.
module audio_dac_fifo_controller_top #(
  parameter int FIFO_DEPTH = 2048,
  parameter int FRAC_BITS  = 12
) (
  input  logic        clk,
  input  logic        rst,
  adfc_in_if.sink     in_ch,
  adfc_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [16:0] cfg_data
);
  import adfc_pkg::*;

  localparam int AW    = $clog2(FIFO_DEPTH);
  localparam int PW    = AW + FRAC_BITS;
  localparam int NW    = PW + 2;
  localparam int W_NUM = 20 + FRAC_BITS;
  localparam int CW    = $clog2(W_NUM + 1);
  localparam logic [NW-1:0] SPAN    = NW'(FIFO_DEPTH) << FRAC_BITS;
  localparam logic [NW-1:0] ONE     = NW'(1) << FRAC_BITS;
  localparam logic [NW-1:0] NEAR_TH = NW'(128) << FRAC_BITS;
  localparam logic [NW-1:0] FULL_TH = NW'(FIFO_DEPTH - 1) << FRAC_BITS;

  logic [7:0] mem [FIFO_DEPTH];
  logic [7:0] mem_q;

  state_t state, state_next;
  logic [16:0] rate;
  logic [2:0] kind;
  logic [7:0] data;
  logic [PW-1:0] rpos;
  logic [AW-1:0] wslot;
  logic [NW-1:0] pend;
  logic [15:0] step;
  logic [7:0] bias, cmd, divb, lvl;
  logic fresh, armed, flag, level;
  logic [AW-1:0] clr_idx;
  logic [7:0] rd, smp;
  logic [W_NUM-1:0] num;
  logic [W_NUM-1:0] quo;
  logic [17:0] rem;
  logic [CW-1:0] cnt;
  logic dphase;
  logic [7:0] dv;

  logic full, near, empty;
  logic [7:0] status;
  logic [16:0] dsr;
  logic [17:0] rem_sh;
  logic [18:0] rem_sub;

  assign full   = pend > FULL_TH;
  assign empty  = pend == '0;
  assign near   = (pend < NEAR_TH) && (cmd[1:0] == 2'b11);
  assign status = (flag ? ST_IRQ : 8'd0) | (empty ? ST_EMPTY : 8'd0) |
                  (near ? ST_NEAR : 8'd0) | (full ? ST_FULL : 8'd0);
  assign dsr     = dphase ? rate : {9'd0, dv};
  assign rem_sh  = {rem[16:0], num[W_NUM-1]};
  assign rem_sub = {1'b0, rem_sh} - {2'b0, dsr};

  assign in_ch.ready      = (state == S_IDLE) && !out_ch.valid;
  assign out_ch.read_data = rd;
  assign out_ch.sample    = smp;
  assign out_ch.irq_line  = level;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_ch.valid && in_ch.ready) state_next = S_EXEC;
      S_CLEAR: if (clr_idx == AW'(FIFO_DEPTH - 1)) state_next = S_IDLE;
      S_EXEC: begin
        case (kind)
          K_DIV: state_next = S_DIV;
          K_TICK: state_next = S_TICK;
          K_LEVEL: state_next = (data == 8'd0) ? S_CLEAR : S_OUT;
          default: state_next = S_OUT;
        endcase
      end
      S_DIV: if (dphase && cnt == CW'(W_NUM)) state_next = S_OUT;
      S_TICK: state_next = S_OUT;
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[rpos[PW-1:FRAC_BITS]];
    if (state == S_CLEAR) mem[clr_idx] <= MIDLINE;
    else if (state == S_EXEC && kind == K_DATA) begin
      if (!full) mem[wslot] <= data - ((fresh && data != 8'd0) ? data - MIDLINE : bias);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      rate <= 17'd48000;
      rpos <= '0; wslot <= '0; pend <= '0; step <= '0; bias <= '0;
      cmd <= '0; divb <= '0; lvl <= '0;
      fresh <= 1'b1; armed <= 1'b0; flag <= 1'b0; level <= 1'b0;
      clr_idx <= '0; out_ch.valid <= 1'b0;
      rd <= '0; smp <= MIDLINE; cnt <= '0; dphase <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) rate <= cfg_data;
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          clr_idx <= '0;
          if (in_ch.valid && in_ch.ready) begin
            kind <= in_ch.kind; data <= in_ch.data;
            rd <= '0; smp <= MIDLINE; dphase <= 1'b0; cnt <= '0;
          end
        end
        S_CLEAR: clr_idx <= clr_idx + 1'b1;
        S_EXEC: begin
          case (kind)
            K_DATA: begin
              if (fresh) begin
                fresh <= 1'b0;
                if (data != 8'd0) bias <= data - MIDLINE;
              end
              if (!full) begin
                wslot <= (wslot == AW'(FIFO_DEPTH - 1)) ? '0 : wslot + 1'b1;
                pend <= (pend + ONE > SPAN) ? SPAN : pend + ONE;
              end
            end
            K_CTRL: begin
              cmd <= data;
              if (data[1:0] != 2'b00) armed <= 1'b1;
            end
            K_DIV: begin
              divb <= data;
              dv <= (data < MIN_DIV) ? FALLBACK_DIV : data;
              num <= W_NUM'(CLOCK_HZ) << FRAC_BITS;
              rem <= '0; quo <= '0;
            end
            K_LEVEL: begin
              lvl <= data;
              if (data == 8'd0) begin
                rpos <= '0; wslot <= '0; pend <= '0; step <= '0;
                armed <= 1'b0; level <= 1'b0; fresh <= 1'b1;
                out_ch.valid <= 1'b1;
              end
            end
            K_STATUS: rd <= status;
            K_CMD: rd <= cmd;
            K_DIVRD: rd <= divb;
            default: begin
              if (near && armed) begin
                flag <= 1'b1; armed <= 1'b0; level <= 1'b1;
              end
            end
          endcase
        end
        S_DIV: begin
          // phase 0: 1e6/div over 20 steps; phase 1: (q<<F)/rate over W_NUM steps
          if (!dphase) begin
            if (cnt == CW'(20)) begin
              num <= quo << FRAC_BITS;
              quo <= '0; rem <= '0; cnt <= '0; dphase <= 1'b1;
            end else begin
              cnt <= cnt + 1'b1;
              num <= num << 1;
              if (!rem_sub[18]) begin
                rem <= rem_sub[17:0]; quo <= {quo[W_NUM-2:0], 1'b1};
              end else begin
                rem <= rem_sh; quo <= {quo[W_NUM-2:0], 1'b0};
              end
            end
          end else if (cnt == CW'(W_NUM)) begin
            if (rate == '0 || quo > W_NUM'(STEP_MAX)) step <= STEP_MAX;
            else step <= quo[15:0];
            if (near && armed) begin
              flag <= 1'b1; armed <= 1'b0; level <= 1'b1;
            end
          end else begin
            cnt <= cnt + 1'b1;
            num <= num << 1;
            if (!rem_sub[18]) begin
              rem <= rem_sub[17:0]; quo <= {quo[W_NUM-2:0], 1'b1};
            end else begin
              rem <= rem_sh; quo <= {quo[W_NUM-2:0], 1'b0};
            end
          end
        end
        S_TICK: begin
          if (!empty) begin
            smp <= mem_q;
            rpos <= rpos + PW'(step);
            pend <= (pend > NW'(step)) ? pend - NW'(step) : '0;
          end
        end
        S_OUT: out_ch.valid <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule
